// ===== sv/m1ump_pkg.sv =====
`timescale 1ns / 1ps
package m1ump_pkg;

  localparam int QUEUE_DEPTH = 2;
  localparam int HOLD_DEPTH  = 6;

  localparam logic [7:0] BYTE_SOX      = 8'hF0;
  localparam logic [7:0] BYTE_SC_F4    = 8'hF4;
  localparam logic [7:0] BYTE_SC_F5    = 8'hF5;
  localparam logic [7:0] BYTE_TUNE_REQ = 8'hF6;
  localparam logic [7:0] BYTE_EOX      = 8'hF7;
  localparam logic [7:0] BYTE_RT_FIRST = 8'hF8;
  localparam logic [7:0] BYTE_RT_F9    = 8'hF9;
  localparam logic [7:0] BYTE_RT_FD    = 8'hFD;

  localparam logic [3:0] MT_SYSTEM  = 4'h1;
  localparam logic [3:0] MT_CHANNEL = 4'h2;
  localparam logic [3:0] MT_SYSEX   = 4'h3;
  localparam logic [3:0] GROUP      = 4'h0;

  localparam logic [3:0] SX_COMPLETE = 4'h0;
  localparam logic [3:0] SX_START    = 4'h1;
  localparam logic [3:0] SX_CONTINUE = 4'h2;
  localparam logic [3:0] SX_END      = 4'h3;

  localparam logic [1:0] WC_SHORT = 2'd1;
  localparam logic [1:0] WC_LONG  = 2'd2;

  localparam logic [31:0] TUNE_REQ_WORD = 32'h10F6_0000;

  typedef enum logic [2:0] {
    CLS_RT,
    CLS_DROP,
    CLS_EOX,
    CLS_SOX,
    CLS_SC_UNDEF,
    CLS_STATUS,
    CLS_DATA
  } byte_cls_t;

  typedef struct packed {
    byte_cls_t  cls;
    logic [7:0] data;
  } q_entry_t;

  function automatic logic [1:0] data_count(input logic [7:0] st);
    logic [1:0] n;
    n = 2'd0;
    if (st[7] && st[7:4] != 4'hF) begin
      n = (st[7:4] == 4'hC || st[7:4] == 4'hD) ? 2'd1 : 2'd2;
    end else if (st == 8'hF1 || st == 8'hF3) begin
      n = 2'd1;
    end else if (st == 8'hF2) begin
      n = 2'd2;
    end
    return n;
  endfunction

endpackage

// ===== sv/m1ump_byte_if.sv =====
`timescale 1ns / 1ps
interface m1ump_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] midi_byte;

  modport source (output valid, output midi_byte, input ready);
  modport sink (input valid, input midi_byte, output ready);
endinterface

// ===== sv/m1ump_pkt_if.sv =====
`timescale 1ns / 1ps
interface m1ump_pkt_if;
  logic        valid;
  logic        ready;
  logic [1:0]  word_count;
  logic [31:0] first_word;
  logic [31:0] second_word;

  modport source (output valid, output word_count, output first_word,
                  output second_word, input ready);
  modport sink (input valid, input word_count, input first_word,
                input second_word, output ready);
endinterface

// ===== sv/m1ump_front.sv =====
`timescale 1ns / 1ps
module m1ump_front (
  m1ump_byte_if.sink         midi,
  output logic               push_valid,
  input  logic               push_ready,
  output m1ump_pkg::q_entry_t push_entry
);

  m1ump_pkg::byte_cls_t cls;
  logic [7:0]           b;

  assign b = midi.midi_byte;

  always_comb begin
    if (b == m1ump_pkg::BYTE_RT_F9 || b == m1ump_pkg::BYTE_RT_FD) begin
      cls = m1ump_pkg::CLS_DROP;
    end else if (b >= m1ump_pkg::BYTE_RT_FIRST) begin
      cls = m1ump_pkg::CLS_RT;
    end else if (b == m1ump_pkg::BYTE_EOX) begin
      cls = m1ump_pkg::CLS_EOX;
    end else if (b == m1ump_pkg::BYTE_SOX) begin
      cls = m1ump_pkg::CLS_SOX;
    end else if (b == m1ump_pkg::BYTE_SC_F4 || b == m1ump_pkg::BYTE_SC_F5) begin
      cls = m1ump_pkg::CLS_SC_UNDEF;
    end else if (b[7]) begin
      cls = m1ump_pkg::CLS_STATUS;
    end else begin
      cls = m1ump_pkg::CLS_DATA;
    end
  end

  assign push_valid      = midi.valid;
  assign midi.ready      = push_ready;
  assign push_entry.cls  = cls;
  assign push_entry.data = b;

endmodule

// ===== sv/m1ump_queue.sv =====
`timescale 1ns / 1ps
module m1ump_queue #(
  parameter int DEPTH = m1ump_pkg::QUEUE_DEPTH
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                push_valid,
  output logic                push_ready,
  input  m1ump_pkg::q_entry_t push_entry,
  output logic                pop_valid,
  input  logic                pop_ready,
  output m1ump_pkg::q_entry_t pop_entry
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  m1ump_pkg::q_entry_t slots [DEPTH];
  logic [AW-1:0] wr_ptr;
  logic [AW-1:0] rd_ptr;
  logic [CW-1:0] count;
  logic          push;
  logic          pop;

  assign push_ready = (count != CW'(DEPTH));
  assign pop_valid  = (count != '0);
  assign push       = push_valid && push_ready;
  assign pop        = pop_ready && pop_valid;
  assign pop_entry  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// ===== sv/m1ump_back.sv =====
`timescale 1ns / 1ps
module m1ump_back (
  input  logic                clk,
  input  logic                rst,
  input  logic                pop_valid,
  output logic                pop_ready,
  input  m1ump_pkg::q_entry_t pop_entry,
  m1ump_pkt_if.source         ump
);

  localparam int HD = m1ump_pkg::HOLD_DEPTH;

  logic [7:0] current_status, current_status_next;
  logic [7:0] running_status, running_status_next;
  logic [2:0] bytes_held, bytes_held_next;
  logic [1:0] bytes_needed, bytes_needed_next;
  logic       in_sysex, in_sysex_next;
  logic       sysex_continued, sysex_continued_next;
  logic [7:0] hold_buffer [HD];

  logic        out_valid;
  logic [1:0]  out_count;
  logic [31:0] out_w0;
  logic [31:0] out_w1;

  logic        pop;
  logic        emit;
  logic [1:0]  emit_count;
  logic [31:0] emit_w0;
  logic [31:0] emit_w1;
  logic        wr_en;
  logic [2:0]  wr_idx;
  logic [7:0]  b;
  logic [7:0]  held_b [HD];
  logic [7:0]  cs;
  logic [1:0]  nd;
  logic [2:0]  h;
  logic [2:0]  h1;
  logic [7:0]  new0;
  logic [7:0]  new1;
  logic [3:0]  sx_kind;

  assign b         = pop_entry.data;
  assign pop_ready = !out_valid || ump.ready;
  assign pop       = pop_valid && pop_ready;

  always_comb begin
    for (int i = 0; i < HD; i++) begin
      held_b[i] = (3'(i) < bytes_held) ? hold_buffer[i] : 8'h00;
    end
  end

  always_comb begin
    current_status_next  = current_status;
    running_status_next  = running_status;
    bytes_held_next      = bytes_held;
    bytes_needed_next    = bytes_needed;
    in_sysex_next        = in_sysex;
    sysex_continued_next = sysex_continued;
    emit       = 1'b0;
    emit_count = m1ump_pkg::WC_SHORT;
    emit_w0    = '0;
    emit_w1    = '0;
    wr_en      = 1'b0;
    wr_idx     = '0;
    sx_kind    = m1ump_pkg::SX_COMPLETE;
    cs   = (current_status == 8'h00) ? running_status : current_status;
    nd   = (current_status == 8'h00) ? m1ump_pkg::data_count(running_status)
                                     : bytes_needed;
    h    = (bytes_held >= 3'(HD)) ? 3'd0 : bytes_held;
    h1   = h + 3'd1;
    new0 = (h == 3'd0) ? b : hold_buffer[0];
    new1 = (h == 3'd1) ? b : hold_buffer[1];

    unique case (pop_entry.cls)
      m1ump_pkg::CLS_RT: begin
        emit    = 1'b1;
        emit_w0 = {m1ump_pkg::MT_SYSTEM, m1ump_pkg::GROUP, b, 16'h0000};
      end
      m1ump_pkg::CLS_DROP: begin
      end
      m1ump_pkg::CLS_EOX: begin
        if (!in_sysex) begin
          current_status_next = '0;
          running_status_next = '0;
          bytes_held_next     = '0;
          bytes_needed_next   = '0;
        end else begin
          in_sysex_next   = 1'b0;
          emit            = 1'b1;
          emit_count      = m1ump_pkg::WC_LONG;
          sx_kind         = sysex_continued ? m1ump_pkg::SX_END
                                            : m1ump_pkg::SX_COMPLETE;
          bytes_held_next = '0;
        end
      end
      m1ump_pkg::CLS_SOX, m1ump_pkg::CLS_SC_UNDEF, m1ump_pkg::CLS_STATUS: begin
        current_status_next  = '0;
        running_status_next  = '0;
        bytes_held_next      = '0;
        bytes_needed_next    = '0;
        in_sysex_next        = (pop_entry.cls == m1ump_pkg::CLS_SOX);
        sysex_continued_next = 1'b0;
        if (pop_entry.cls == m1ump_pkg::CLS_STATUS) begin
          current_status_next = b;
          if (b[7:4] != 4'hF) begin
            running_status_next = b;
          end
          bytes_needed_next = m1ump_pkg::data_count(b);
          if (b == m1ump_pkg::BYTE_TUNE_REQ) begin
            emit    = 1'b1;
            emit_w0 = m1ump_pkg::TUNE_REQ_WORD;
          end
        end
      end
      m1ump_pkg::CLS_DATA: begin
        if (in_sysex) begin
          wr_en = 1'b1;
          if (bytes_held >= 3'(HD)) begin
            emit                 = 1'b1;
            emit_count           = m1ump_pkg::WC_LONG;
            sx_kind              = sysex_continued ? m1ump_pkg::SX_CONTINUE
                                                   : m1ump_pkg::SX_START;
            sysex_continued_next = 1'b1;
            wr_idx               = '0;
            bytes_held_next      = 3'd1;
          end else begin
            wr_idx          = bytes_held;
            bytes_held_next = bytes_held + 3'd1;
          end
        end else begin
          current_status_next = cs;
          bytes_needed_next   = nd;
          if (nd != 2'd0) begin
            wr_en  = 1'b1;
            wr_idx = h;
            if (h1 < {1'b0, nd}) begin
              bytes_held_next = h1;
            end else begin
              emit    = 1'b1;
              emit_w0 = {(cs[7:4] != 4'hF) ? m1ump_pkg::MT_CHANNEL : m1ump_pkg::MT_SYSTEM,
                         m1ump_pkg::GROUP, cs, new0,
                         (nd == 2'd2) ? new1 : 8'h00};
              bytes_held_next     = '0;
              current_status_next = running_status;
              bytes_needed_next   = m1ump_pkg::data_count(running_status);
            end
          end
        end
      end
      default: begin
      end
    endcase

    if (emit_count == m1ump_pkg::WC_LONG) begin
      emit_w0 = {m1ump_pkg::MT_SYSEX, m1ump_pkg::GROUP, sx_kind, 1'b0, bytes_held,
                 held_b[0], held_b[1]};
      emit_w1 = {held_b[2], held_b[3], held_b[4], held_b[5]};
    end
  end

  always_ff @(posedge clk) begin
    if (pop && wr_en) begin
      hold_buffer[wr_idx] <= b;
    end
    if (pop && emit) begin
      out_count <= emit_count;
      out_w0    <= emit_w0;
      out_w1    <= emit_w1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      current_status  <= '0;
      running_status  <= '0;
      bytes_held      <= '0;
      bytes_needed    <= '0;
      in_sysex        <= 1'b0;
      sysex_continued <= 1'b0;
      out_valid       <= 1'b0;
    end else begin
      if (pop) begin
        current_status  <= current_status_next;
        running_status  <= running_status_next;
        bytes_held      <= bytes_held_next;
        bytes_needed    <= bytes_needed_next;
        in_sysex        <= in_sysex_next;
        sysex_continued <= sysex_continued_next;
        out_valid       <= emit;
      end else if (ump.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  assign ump.valid       = out_valid;
  assign ump.word_count  = out_count;
  assign ump.first_word  = out_w0;
  assign ump.second_word = out_w1;

endmodule

// ===== sv/midi1_bytes_to_ump_top.sv =====
// Channel  Dir  Fields                               Request
// midi     in   midi_byte[7:0]                       one raw MIDI 1.0 byte
// ump      out  word_count[1:0] first_word[31:0]     one UMP packet, group 0
//               second_word[31:0]
//
// One byte per cycle sustained while the output is not stalled; a byte taken
// into the queue is popped by the back, which updates its message state and
// registers any packet that the byte completes.
// Reset (rst, synchronous) empties the queue and clears the message state.
// An output stall holds the packet; the queue keeps taking bytes until full.
`timescale 1ns / 1ps
module midi1_bytes_to_ump_top #(
  parameter int QUEUE_DEPTH = m1ump_pkg::QUEUE_DEPTH
) (
  input logic         clk,
  input logic         rst,
  m1ump_byte_if.sink  midi,
  m1ump_pkt_if.source ump
);

  logic                push_valid;
  logic                push_ready;
  m1ump_pkg::q_entry_t push_entry;
  logic                pop_valid;
  logic                pop_ready;
  m1ump_pkg::q_entry_t pop_entry;

  m1ump_front u_front (
    .midi       (midi),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_entry (push_entry)
  );

  m1ump_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_entry (push_entry),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_entry  (pop_entry)
  );

  m1ump_back u_back (
    .clk       (clk),
    .rst       (rst),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_entry (pop_entry),
    .ump       (ump)
  );

endmodule

// ===== sv/m1ump_checker.sv =====
`timescale 1ns / 1ps
module m1ump_checker (
  input logic        clk,
  input logic        rst,
  input logic        out_valid,
  input logic        out_ready,
  input logic [1:0]  word_count,
  input logic [31:0] first_word,
  input logic [31:0] second_word
);

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(first_word)
      && $stable(second_word) && $stable(word_count))
    else $error("packet changed while stalled");

  a_count: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (word_count == 2'd1 || word_count == 2'd2))
    else $error("bad word count");

  a_short: assert property (@(posedge clk) disable iff (rst)
    out_valid && word_count == 2'd1 |-> second_word == 32'h0
      && first_word[27:24] == 4'h0
      && (first_word[31:28] == 4'h1 || first_word[31:28] == 4'h2))
    else $error("malformed 32-bit packet");

  a_sysex: assert property (@(posedge clk) disable iff (rst)
    out_valid && word_count == 2'd2 |-> first_word[31:24] == 8'h30
      && first_word[19:16] <= 4'd6 && first_word[23:22] == 2'b00)
    else $error("malformed sysex packet");

endmodule

bind midi1_bytes_to_ump_top m1ump_checker u_m1ump_checker (
  .clk         (clk),
  .rst         (rst),
  .out_valid   (ump.valid),
  .out_ready   (ump.ready),
  .word_count  (ump.word_count),
  .first_word  (ump.first_word),
  .second_word (ump.second_word)
);

// ===== tb/tb_midi1_bytes_to_ump_top.sv =====
`timescale 1ns / 1ps
module tb_midi1_bytes_to_ump_top;
  import m1ump_pkg::*;

  localparam int CYCLE_LIMIT     = 200000;
  localparam int ITEMS_PER_PHASE = 440;
  localparam int TAIL_CYCLES     = 20;
  localparam int HOLD_OFF_CYCLES = 300;
  localparam int MAX_REPORTS     = 10;

  localparam logic [7:0] BYTE_MTC      = 8'hF1;
  localparam logic [7:0] BYTE_SPP      = 8'hF2;
  localparam logic [7:0] BYTE_SONG_SEL = 8'hF3;
  localparam logic [3:0] NIB_PROGRAM   = 4'hC;
  localparam logic [3:0] NIB_PRESSURE  = 4'hD;
  localparam logic [3:0] NIB_SYSTEM    = 4'hF;

  typedef struct packed {
    logic [1:0]  word_count;
    logic [31:0] first_word;
    logic [31:0] second_word;
  } ump_packet_t;

  logic clk;
  logic rst;

  m1ump_byte_if midi ();
  m1ump_pkt_if  ump ();

  midi1_bytes_to_ump_top i_dut (
    .clk  (clk),
    .rst  (rst),
    .midi (midi),
    .ump  (ump)
  );

  // translator state
  logic [7:0] cur_status;
  logic [7:0] run_status;
  logic [2:0] held_count;
  logic [1:0] need_count;
  logic       sysex_open;
  logic       sysex_started;
  logic [7:0] held_bytes [HOLD_DEPTH];

  logic [7:0]  midi_stream [$];
  ump_packet_t expected_packets [$];

  int  bytes_queued = 0;
  int  bytes_accepted = 0;
  int  error_count = 0;
  int  cycle_count = 0;
  int  tx_idle_pct = 0;
  int  rx_idle_pct = 0;
  int  hold_off_at = 0;
  bit  rx_hold = 1'b0;

  function automatic logic [1:0] data_bytes_for(input logic [7:0] st);
    if (st[7] && st[7:4] != NIB_SYSTEM) begin
      return (st[7:4] == NIB_PROGRAM || st[7:4] == NIB_PRESSURE) ? 2'd1 : 2'd2;
    end
    if (st == BYTE_MTC || st == BYTE_SONG_SEL) return 2'd1;
    if (st == BYTE_SPP) return 2'd2;
    return 2'd0;
  endfunction

  task automatic clear_message();
    cur_status = '0;
    run_status = '0;
    held_count = '0;
    need_count = '0;
  endtask

  task automatic reset_translator();
    clear_message();
    sysex_open    = 1'b0;
    sysex_started = 1'b0;
    foreach (held_bytes[i]) held_bytes[i] = '0;
  endtask

  task automatic pack_sysex(input logic [3:0] kind, output ump_packet_t pkt);
    pkt.word_count  = WC_LONG;
    pkt.first_word  = {MT_SYSEX, GROUP, kind, 1'b0, held_count, 16'h0000};
    pkt.second_word = '0;
    for (int i = 0; i < held_count; i++) begin
      if (i < 2) pkt.first_word[15 - 8 * i -: 8] = held_bytes[i];
      else pkt.second_word[31 - 8 * (i - 2) -: 8] = held_bytes[i];
    end
    held_count = '0;
  endtask

  task automatic translate_byte(input logic [7:0] b, output bit emitted,
                                output ump_packet_t pkt);
    emitted = 1'b0;
    pkt = '0;
    if (b >= BYTE_RT_FIRST) begin
      if (b != BYTE_RT_F9 && b != BYTE_RT_FD) begin
        emitted = 1'b1;
        pkt.word_count = WC_SHORT;
        pkt.first_word = {MT_SYSTEM, GROUP, b, 16'h0000};
      end
    end else if (b == BYTE_EOX) begin
      if (!sysex_open) begin
        clear_message();
      end else begin
        sysex_open = 1'b0;
        pack_sysex(sysex_started ? SX_END : SX_COMPLETE, pkt);
        emitted = 1'b1;
      end
    end else if (b[7]) begin
      clear_message();
      sysex_open    = 1'b0;
      sysex_started = 1'b0;
      if (b == BYTE_SOX) begin
        sysex_open = 1'b1;
      end else if (b != BYTE_SC_F4 && b != BYTE_SC_F5) begin
        cur_status = b;
        if (b < BYTE_SOX) run_status = b;
        need_count = data_bytes_for(b);
        if (need_count == 0 && b == BYTE_TUNE_REQ) begin
          emitted = 1'b1;
          pkt.word_count = WC_SHORT;
          pkt.first_word = TUNE_REQ_WORD;
        end
      end
    end else if (sysex_open) begin
      if (held_count >= HOLD_DEPTH) begin
        pack_sysex(sysex_started ? SX_CONTINUE : SX_START, pkt);
        emitted       = 1'b1;
        sysex_started = 1'b1;
        held_bytes[0] = b;
        held_count    = 3'd1;
      end else begin
        held_bytes[held_count] = b;
        held_count++;
      end
    end else begin
      if (cur_status == 0) begin
        cur_status = run_status;
        need_count = data_bytes_for(cur_status);
      end
      if (need_count != 0) begin
        if (held_count >= HOLD_DEPTH) held_count = '0;
        held_bytes[held_count] = b;
        held_count++;
        if (held_count >= need_count) begin
          emitted = 1'b1;
          pkt.word_count = WC_SHORT;
          pkt.first_word = {(cur_status < BYTE_SOX) ? MT_CHANNEL : MT_SYSTEM, GROUP,
                            cur_status, held_bytes[0],
                            (need_count == 2) ? held_bytes[1] : 8'h00};
          held_count = '0;
          cur_status = run_status;
          need_count = data_bytes_for(cur_status);
        end
      end
    end
  endtask

  // random real-time bytes are sprinkled into the stream
  task automatic queue_byte(input logic [7:0] b);
    if ($urandom_range(24) == 0) begin
      midi_stream.push_back(8'($urandom_range(8'hF8, 8'hFF)));
      bytes_queued++;
    end
    midi_stream.push_back(b);
    bytes_queued++;
  endtask

  task automatic queue_random_bytes(input int count);
    int start;
    int pick;
    int len;
    logic [7:0] st;
    start = bytes_queued;
    while (bytes_queued - start < count) begin
      pick = $urandom_range(99);
      if (pick < 40) begin
        st = {4'($urandom_range(8, 14)), 4'($urandom())};
        queue_byte(st);
        repeat ($urandom_range(1, 3)) begin
          repeat (data_bytes_for(st)) queue_byte(8'($urandom_range(127)));
        end
      end else if (pick < 55) begin
        case ($urandom_range(3))
          0: st = BYTE_MTC;
          1: st = BYTE_SPP;
          2: st = BYTE_SONG_SEL;
          default: st = BYTE_TUNE_REQ;
        endcase
        queue_byte(st);
        repeat (data_bytes_for(st)) queue_byte(8'($urandom_range(127)));
      end else if (pick < 80) begin
        len = $urandom_range(1) ? 6 * $urandom_range(0, 3) : $urandom_range(0, 20);
        queue_byte(BYTE_SOX);
        repeat (len) queue_byte(8'($urandom_range(127)));
        if ($urandom_range(6) != 0) queue_byte(BYTE_EOX);
        else queue_byte(8'($urandom_range(8'h80, 8'hF6)));
      end else begin
        repeat ($urandom_range(1, 3)) queue_byte(8'($urandom()));
      end
    end
  endtask

  task automatic wait_drained();
    @(negedge clk iff (midi_stream.size() == 0 && !midi.valid &&
                       expected_packets.size() == 0));
  endtask

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("tb_midi1_bytes_to_ump_top failed");
      $finish;
    end
  end

  // byte driver
  always @(posedge clk) begin
    bit          emitted;
    ump_packet_t pkt;
    if (rst) begin
      midi.valid <= 1'b0;
    end else begin
      if (midi.valid && midi.ready) begin
        translate_byte(midi.midi_byte, emitted, pkt);
        if (emitted) expected_packets.push_back(pkt);
        bytes_accepted++;
      end
      if (!midi.valid || midi.ready) begin
        if (midi_stream.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
          midi.valid     <= 1'b1;
          midi.midi_byte <= midi_stream.pop_front();
        end else begin
          midi.valid <= 1'b0;
        end
      end
    end
  end

  // packet monitor
  always @(posedge clk) begin
    ump_packet_t got;
    ump_packet_t want;
    if (rst) begin
      ump.ready <= 1'b0;
    end else begin
      if (ump.valid && ump.ready) begin
        got = '{ump.word_count, ump.first_word, ump.second_word};
        if (expected_packets.size() == 0) begin
          if (error_count < MAX_REPORTS)
            $display("%0t: unexpected packet wc=%0d w0=%h w1=%h", $time,
                     got.word_count, got.first_word, got.second_word);
          error_count++;
        end else begin
          want = expected_packets.pop_front();
          if (got.word_count !== want.word_count || got.first_word !== want.first_word ||
              got.second_word !== want.second_word) begin
            if (error_count < MAX_REPORTS)
              $display("%0t: packet mismatch, expected wc=%0d w0=%h w1=%h, got wc=%0d w0=%h w1=%h",
                       $time, want.word_count, want.first_word, want.second_word,
                       got.word_count, got.first_word, got.second_word);
            error_count++;
          end
        end
      end
      ump.ready <= !rx_hold && ($urandom_range(99) >= rx_idle_pct);
    end
  end

  // long output stall so the input queue backs up
  initial begin
    @(posedge clk iff (hold_off_at != 0 && bytes_accepted >= hold_off_at));
    rx_hold <= 1'b1;
    repeat (HOLD_OFF_CYCLES) @(posedge clk);
    rx_hold <= 1'b0;
  end

  initial begin
    logic [7:0] directed_bytes [$];
    directed_bytes = '{
      8'h00,                                  // stray data, no status
      BYTE_RT_F9, BYTE_RT_FD, 8'hFF,
      8'h80, 8'h7F, 8'h7F, 8'h00, 8'h00,      // note off, then running status
      BYTE_SONG_SEL, 8'h12, 8'h05,            // running status cleared
      BYTE_SC_F4, BYTE_SC_F5, BYTE_EOX,
      BYTE_SOX, 8'h01, 8'h02, 8'h03, 8'h04, 8'h05, 8'h06, BYTE_EOX,
      BYTE_SOX, 8'h7F, BYTE_TUNE_REQ,         // sysex cut by status
      BYTE_RT_FIRST, 8'hCF, 8'h7F, BYTE_MTC, 8'h55, BYTE_SPP, 8'h01, 8'h7F
    };
    rst            = 1'b1;
    midi.valid     = 1'b0;
    midi.midi_byte = '0;
    ump.ready      = 1'b0;
    reset_translator();
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);
    foreach (directed_bytes[i]) begin
      midi_stream.push_back(directed_bytes[i]);
      bytes_queued++;
    end
    wait_drained();

    tx_idle_pct = 31;
    rx_idle_pct = 81;
    queue_random_bytes(ITEMS_PER_PHASE);
    wait_drained();

    tx_idle_pct = 81;
    rx_idle_pct = 31;
    queue_random_bytes(ITEMS_PER_PHASE);
    wait_drained();

    tx_idle_pct = 0;
    rx_idle_pct = 0;
    hold_off_at = bytes_accepted + 60;
    queue_random_bytes(ITEMS_PER_PHASE);
    wait_drained();

    repeat (TAIL_CYCLES) @(negedge clk);
    error_count += expected_packets.size();
    if (error_count == 0) begin
      $display("tb_midi1_bytes_to_ump_top passed");
    end else begin
      $display("tb_midi1_bytes_to_ump_top failed");
    end
    $finish;
  end

endmodule
